/* design/bba_pkg.sv */
package bba_pkg;

    // map geometry
    localparam int NUM_BLOCKS    = 16384;
    localparam int MAP_WORD_BITS = 64;
    localparam int MAP_WORDS     = NUM_BLOCKS / MAP_WORD_BITS;
    localparam int BLOCK_W       = $clog2(NUM_BLOCKS);
    localparam int BIT_IDX_W     = $clog2(MAP_WORD_BITS);
    localparam int WORD_IDX_W    = $clog2(MAP_WORDS);
    localparam int RES_W         = 15;

    typedef logic [MAP_WORD_BITS-1:0] word_t;
    typedef logic [WORD_IDX_W-1:0]    word_idx_t;
    typedef logic [BIT_IDX_W-1:0]     bit_idx_t;
    typedef logic [BLOCK_W-1:0]       block_t;
    typedef logic [RES_W-1:0]         res_t;

    localparam word_t     WORD_ONES = '1;
    localparam word_idx_t LAST_WORD = word_idx_t'(MAP_WORDS - 1);

    // request opcodes
    localparam logic OP_ALLOC   = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    // result codes
    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_FULL        = 2'd1,
        ST_BAD_RELEASE = 2'd2
    } status_t;

    // free map access from the sequencer
    typedef struct packed {
        logic      rd_en;
        word_idx_t rd_addr;
        logic      wr_en;
        word_idx_t wr_addr;
    } map_req_t;

    // answer of the lowest free bit search
    typedef struct packed {
        logic     found;
        bit_idx_t pos;
    } find_res_t;

endpackage

/* design/bba_find.sv */
module bba_find (
    input  bba_pkg::word_t     word,
    input  logic               first,
    input  bba_pkg::bit_idx_t  offset,
    output bba_pkg::find_res_t res,
    output bba_pkg::word_t     onehot
);
    import bba_pkg::*;

    word_t masked;
    word_t lowest;

    // drop the reserved blocks on the first word of a scan
    assign masked = word & (first ? (WORD_ONES << offset) : WORD_ONES);

    // isolate the lowest set bit
    assign lowest = masked & (~masked + word_t'(1));
    assign onehot = lowest;

    // encode the isolated bit
    always_comb
    begin
        res.found = |masked;
        res.pos   = '0;
        for (int i = 0; i < MAP_WORD_BITS; i++)
        begin
            if (lowest[i])
            begin
                res.pos = res.pos | bit_idx_t'(i);
            end
        end
    end

endmodule

/* design/bba_map.sv */
module bba_map (
    input  logic              clk,
    input  logic              rst_n,
    input  bba_pkg::map_req_t req,
    input  bba_pkg::word_t    wr_data,
    output bba_pkg::word_t    rd_data
);
    import bba_pkg::*;

    word_t                mem [MAP_WORDS];
    logic [MAP_WORDS-1:0] valid_reg;
    word_t                rd_word_reg;
    logic                 rd_valid_reg;

    // word storage, read data registered
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= wr_data;
        end
        if (req.rd_en)
        begin
            rd_word_reg <= mem[req.rd_addr];
        end
    end

    // written flags, an unwritten word reads as all free
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (req.wr_en)
            begin
                valid_reg[req.wr_addr] <= 1'b1;
            end
            if (req.rd_en)
            begin
                rd_valid_reg <= valid_reg[req.rd_addr];
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_word_reg : WORD_ONES;

endmodule

/* design/bitmap_block_allocator.sv */
// channel   direction  handshake              payload
// input     in         in_valid / in_stall    opcode, block_index
// output    out        out_valid / out_stall  granted_block, status
// config    in         cfg_valid / cfg_ready  cfg_data (reserved_blocks)
//
// one request at a time; after an accepted release out_valid rises through S_EVAL and S_FIN,
// after a rejected release or an allocate with no usable block at all through S_FIN alone
// an allocate raises out_valid through S_FIN after scanning 1 to 256 map words from acceptance,
// one word per cycle through the single read port and the shared bit search
// reset marks the whole map free through per-word flags, no clearing pass
// a new request is taken while the previous result is stalled; its own result then waits
module bitmap_block_allocator (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              opcode,
    input  bba_pkg::block_t   block_index,
    output logic              out_valid,
    input  logic              out_stall,
    output bba_pkg::block_t   granted_block,
    output bba_pkg::status_t  status,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  bba_pkg::res_t     cfg_data
);
    import bba_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EVAL = 3'b010,
        S_FIN  = 3'b100
    } state_t;

    state_t    state_reg, state_next;
    logic      op_reg, op_next;
    block_t    idx_reg, idx_next;
    word_idx_t word_reg, word_next;
    logic      first_reg, first_next;
    res_t      reserved_reg;
    block_t    pend_grant_reg, pend_grant_next;
    status_t   pend_status_reg, pend_status_next;
    logic      out_valid_reg, out_valid_next;
    block_t    granted_reg, granted_next;
    status_t   status_reg, status_next;

    map_req_t  map_req;
    word_t     map_wr_data;
    word_t     map_rd_data;
    find_res_t find_res;
    word_t     find_onehot;

    bba_map u_map (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (map_req),
        .wr_data (map_wr_data),
        .rd_data (map_rd_data)
    );

    bba_find u_find (
        .word   (map_rd_data),
        .first  (first_reg),
        .offset (reserved_reg[BIT_IDX_W-1:0]),
        .res    (find_res),
        .onehot (find_onehot)
    );

    assign in_stall      = (state_reg != S_IDLE);
    assign cfg_ready     = (state_reg == S_IDLE);
    assign out_valid     = out_valid_reg;
    assign granted_block = granted_reg;
    assign status        = status_reg;

    // sequencer
    always_comb
    begin
        state_next       = state_reg;
        op_next          = op_reg;
        idx_next         = idx_reg;
        word_next        = word_reg;
        first_next       = first_reg;
        pend_grant_next  = pend_grant_reg;
        pend_status_next = pend_status_reg;
        out_valid_next   = out_valid_reg & out_stall;
        granted_next     = granted_reg;
        status_next      = status_reg;
        map_req          = '0;
        map_wr_data      = map_rd_data;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next         = opcode;
                    idx_next        = block_index;
                    pend_grant_next = '0;
                    if (opcode == OP_RELEASE)
                    begin
                        if (RES_W'(block_index) < reserved_reg ||
                            RES_W'(block_index) >= RES_W'(NUM_BLOCKS))
                        begin
                            pend_status_next = ST_BAD_RELEASE;
                            state_next       = S_FIN;
                        end
                        else
                        begin
                            word_next       = block_index[BIT_IDX_W +: WORD_IDX_W];
                            map_req.rd_en   = 1'b1;
                            map_req.rd_addr = block_index[BIT_IDX_W +: WORD_IDX_W];
                            state_next      = S_EVAL;
                        end
                    end
                    else if (reserved_reg >= RES_W'(NUM_BLOCKS))
                    begin
                        pend_status_next = ST_FULL;
                        state_next       = S_FIN;
                    end
                    else
                    begin
                        word_next       = reserved_reg[BIT_IDX_W +: WORD_IDX_W];
                        first_next      = 1'b1;
                        map_req.rd_en   = 1'b1;
                        map_req.rd_addr = reserved_reg[BIT_IDX_W +: WORD_IDX_W];
                        state_next      = S_EVAL;
                    end
                end
            end

            S_EVAL:
            begin
                if (op_reg == OP_RELEASE)
                begin
                    // set the released bit
                    map_req.wr_en    = 1'b1;
                    map_req.wr_addr  = word_reg;
                    map_wr_data      = map_rd_data |
                                       (word_t'(1) << idx_reg[BIT_IDX_W-1:0]);
                    pend_status_next = ST_OK;
                    state_next       = S_FIN;
                end
                else if (find_res.found)
                begin
                    // claim the lowest free bit
                    map_req.wr_en    = 1'b1;
                    map_req.wr_addr  = word_reg;
                    map_wr_data      = map_rd_data & ~find_onehot;
                    pend_grant_next  = {word_reg, find_res.pos};
                    pend_status_next = ST_OK;
                    state_next       = S_FIN;
                end
                else if (word_reg == LAST_WORD)
                begin
                    pend_status_next = ST_FULL;
                    state_next       = S_FIN;
                end
                else
                begin
                    // move on to the next word
                    word_next       = word_reg + word_idx_t'(1);
                    first_next      = 1'b0;
                    map_req.rd_en   = 1'b1;
                    map_req.rd_addr = word_reg + word_idx_t'(1);
                end
            end

            S_FIN:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    granted_next   = pend_grant_reg;
                    status_next    = pend_status_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            reserved_reg  <= res_t'(8);
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                reserved_reg <= cfg_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        op_reg          <= op_next;
        idx_reg         <= idx_next;
        word_reg        <= word_next;
        first_reg       <= first_next;
        pend_grant_reg  <= pend_grant_next;
        pend_status_reg <= pend_status_next;
        granted_reg     <= granted_next;
        status_reg      <= status_next;
    end

`ifndef ASSERT_OFF
    // only a successful allocation carries a block number
    a_grant_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && status_reg != ST_OK |-> granted_reg == '0)
        else $error("non-zero block on a failed or release result");

    // the map is written only while a word is being evaluated
    a_write_eval: assert property (@(posedge clk) disable iff (!rst_n)
        map_req.wr_en |-> state_reg == S_EVAL)
        else $error("map write outside evaluation");

    // an accepted transaction goes to evaluation or straight to the result
    a_accept_next: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> state_reg == S_EVAL || state_reg == S_FIN)
        else $error("accepted transaction lost");

    // a finished result reaches the output once the slot is free
    a_fin_out: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_FIN && (!out_valid_reg || !out_stall) |=> out_valid_reg)
        else $error("result not presented");
`endif

endmodule

/* verif/bba_grant_checker.sv */
module bba_grant_checker
    import bba_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    input  logic    in_stall,
    input  logic    opcode,
    input  block_t  block_index,
    input  logic    out_valid,
    input  logic    out_stall,
    input  block_t  granted_block,
    input  status_t status,
    input  logic    cfg_valid,
    input  logic    cfg_ready,
    input  res_t    cfg_data,
    output int      failures,
    output int      outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        block_t  granted;
        status_t code;
    } answer_t;

    // shadow free map, 1 = block free
    word_t   shadow_map [MAP_WORDS];
    res_t    reserved_count;
    answer_t answers_due [$];
    answer_t oldest;

    // apply one request to the shadow map and work out its answer
    function automatic answer_t serve_request(input logic op, input block_t idx);
        answer_t ans;
        int      blk;
        int      w;
        logic    hit;
        ans.granted = '0;
        ans.code = ST_OK;
        if (op == OP_ALLOC)
        begin
            blk = int'(reserved_count);
            hit = 1'b0;
            while (!hit && blk < NUM_BLOCKS)
            begin
                w = blk / MAP_WORD_BITS;
                // whole word taken: skip to the next word
                if (shadow_map[w] == '0)
                begin
                    blk = (w + 1) * MAP_WORD_BITS;
                end
                else if (shadow_map[w][blk % MAP_WORD_BITS])
                begin
                    shadow_map[w][blk % MAP_WORD_BITS] = 1'b0;
                    ans.granted = block_t'(blk);
                    hit = 1'b1;
                end
                else
                begin
                    blk++;
                end
            end
            if (!hit)
            begin
                ans.code = ST_FULL;
            end
        end
        else if (int'(idx) < int'(reserved_count) || int'(idx) >= NUM_BLOCKS)
        begin
            ans.code = ST_BAD_RELEASE;
        end
        else
        begin
            shadow_map[int'(idx) / MAP_WORD_BITS][int'(idx) % MAP_WORD_BITS] = 1'b1;
        end
        return ans;
    endfunction

    // follow the three channels, result side first so the oldest answer is used
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int w = 0; w < MAP_WORDS; w++)
            begin
                shadow_map[w] = WORD_ONES;
            end
            reserved_count = res_t'(8);
            answers_due.delete();
            outstanding <= 0;
        end
        else
        begin
            // result transaction
            if (out_valid && !out_stall)
            begin
                if (answers_due.size() == 0)
                begin
                    $error("result with none pending: granted_block %0d status %0d",
                           granted_block, status);
                    failures++;
                end
                else
                begin
                    oldest = answers_due.pop_front();
                    if (granted_block !== oldest.granted)
                    begin
                        $error("granted_block mismatch: expected %0d, actual %0d",
                               oldest.granted, granted_block);
                        failures++;
                    end
                    if (status !== oldest.code)
                    begin
                        $error("status mismatch: expected %0d, actual %0d",
                               oldest.code, status);
                        failures++;
                    end
                end
            end
            // register write transaction
            if (cfg_valid && cfg_ready)
            begin
                reserved_count = cfg_data;
            end
            // request transaction
            if (in_valid && !in_stall)
            begin
                answers_due.push_back(serve_request(opcode, block_index));
            end
            outstanding <= answers_due.size();
        end
    end

endmodule

/* verif/tb_top.sv */
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import bba_pkg::*;

    logic    clk;
    logic    rst_n = 1'b0;
    logic    in_valid = 1'b0;
    logic    in_stall;
    logic    opcode = OP_ALLOC;
    block_t  block_index = '0;
    logic    out_valid;
    logic    out_stall = 1'b0;
    block_t  granted_block;
    status_t status;
    logic    cfg_valid = 1'b0;
    logic    cfg_ready;
    res_t    cfg_data = '0;

    int      failures;
    int      outstanding;
    bit      calm = 1'b0;
    int      reserved_now = 8;

    bitmap_block_allocator DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .opcode        (opcode),
        .block_index   (block_index),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .granted_block (granted_block),
        .status        (status),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    bba_grant_checker grant_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .opcode        (opcode),
        .block_index   (block_index),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .granted_block (granted_block),
        .status        (status),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .failures      (failures),
        .outstanding   (outstanding)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // one request transaction, with an occasional idle burst in front
    task automatic send_request(input logic op, input int idx);
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        in_valid <= 1'b1;
        opcode <= op;
        block_index <= block_t'(idx);
        do @(posedge clk); while (in_stall);
    endtask

    task automatic send_alloc();
        send_request(OP_ALLOC, $urandom_range(0, NUM_BLOCKS - 1));
    endtask

    // drain every answer, then write the reserved count
    task automatic set_reserved(input int value);
        in_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
        cfg_valid <= 1'b1;
        cfg_data <= res_t'(value);
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        reserved_now = value;
    endtask

    // random traffic, releases mostly aimed just above the reserved area
    task automatic run_phase(input int value, input int count, input int alloc_pct);
        int pick;
        int target;
        set_reserved(value);
        repeat (count)
        begin
            pick = $urandom_range(0, 99);
            if (pick < alloc_pct)
            begin
                send_alloc();
            end
            else if (pick < 90)
            begin
                target = reserved_now + $urandom_range(0, 150);
                if (target > NUM_BLOCKS - 1)
                begin
                    target = NUM_BLOCKS - 1 - $urandom_range(0, 63);
                end
                send_request(OP_RELEASE, target);
            end
            else if (pick < 95 && reserved_now > 0)
            begin
                send_request(OP_RELEASE, $urandom_range(0, reserved_now - 1));
            end
            else
            begin
                send_request(OP_RELEASE, $urandom_range(0, NUM_BLOCKS - 1));
            end
        end
    endtask

    // result side back-pressure in random bursts
    initial
    begin
        @(posedge clk);
        forever
        begin
            if (!calm && $urandom_range(0, 2) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 17)) @(posedge clk);
            end
            out_stall <= 1'b0;
            repeat ($urandom_range(1, 24)) @(posedge clk);
        end
    end

    // stimulus and verdict
    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset value of the reserved count
        send_request(OP_ALLOC, 0);
        send_request(OP_ALLOC, NUM_BLOCKS - 1);
        send_request(OP_ALLOC, 5461);
        send_request(OP_RELEASE, 9);
        send_request(OP_ALLOC, 0);
        send_request(OP_RELEASE, 9);
        send_request(OP_RELEASE, 9);
        send_request(OP_RELEASE, 0);
        send_request(OP_RELEASE, 7);
        send_request(OP_RELEASE, 8);
        send_request(OP_RELEASE, NUM_BLOCKS - 1);
        send_request(OP_RELEASE, 10922);
        send_request(OP_RELEASE, 5461);

        // nothing usable
        set_reserved(NUM_BLOCKS);
        send_alloc();
        send_request(OP_RELEASE, NUM_BLOCKS - 1);
        send_request(OP_RELEASE, 0);

        // a single usable block, taken until full
        set_reserved(NUM_BLOCKS - 1);
        send_alloc();
        send_alloc();
        send_request(OP_RELEASE, NUM_BLOCKS - 1);
        send_alloc();
        send_request(OP_RELEASE, NUM_BLOCKS - 1);

        // no reserved blocks at all
        set_reserved(0);
        send_alloc();
        send_request(OP_RELEASE, 0);
        send_alloc();

        // random part, small windows near the top fill up and report full
        run_phase(NUM_BLOCKS - MAP_WORD_BITS, 120, 70);
        run_phase(NUM_BLOCKS - 2 * MAP_WORD_BITS, 120, 65);
        run_phase($urandom_range(0, NUM_BLOCKS), 80, 55);
        run_phase(NUM_BLOCKS, 20, 50);
        run_phase(0, 100, 55);
        run_phase(8, 80, 55);
        run_phase(NUM_BLOCKS - 1, 30, 50);
        calm = 1'b1;
        run_phase($urandom_range(0, NUM_BLOCKS - 1), 80, 55);

        in_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
        repeat (300) @(posedge clk);
        if (failures == 0)
        begin
            $display("[bitmap_block_allocator] OK");
        end
        else
        begin
            $display("[bitmap_block_allocator] ERROR");
        end
        $finish;
    end

    // watchdog
    initial
    begin
        #8000000;
        $display("[bitmap_block_allocator] ERROR");
        $finish;
    end

endmodule

/* filelist.f */
design/bba_pkg.sv
design/bba_find.sv
design/bba_map.sv
design/bitmap_block_allocator.sv
verif/bba_grant_checker.sv
verif/tb_top.sv
